// ===== sv/csc_pkg.sv =====
// Shared types and constants of the CSV shape checker.
`default_nettype none
package csc_pkg;

  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned QueueDepth        = 2;
  localparam int unsigned OutFieldWidth     = 16;
  localparam int unsigned OutDataWidth      = 40;

  localparam logic [7:0] ChrQuote = 8'h22;
  localparam logic [7:0] ChrComma = 8'h2C;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;

  typedef enum logic [2:0] {
    TOK_NONE,
    TOK_QUOTE,
    TOK_COMMA,
    TOK_LF,
    TOK_CR,
    TOK_OTHER
  } tok_e;

  typedef enum logic [2:0] {
    FAULT_NONE       = 3'd0,
    FAULT_EMPTY      = 3'd1,
    FAULT_BLANK      = 3'd2,
    FAULT_MISMATCH   = 3'd3,
    FAULT_OPEN_QUOTE = 3'd4
  } fault_e;

  typedef struct packed {
    tok_e tok;
    logic last;
  } entry_t;

  typedef struct packed {
    logic                     sat;
    fault_e                   fault;
    logic [OutFieldWidth-1:0] records;
    logic [OutFieldWidth-1:0] columns;
    logic                     valid;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/csc_front.sv =====
// Front end: accepts input beats and classifies each byte into a token.
`default_nettype none
module csc_front
  import csc_pkg::*;
(
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,
  input  wire logic       s_axis_tuser,
  input  wire logic       s_axis_tlast,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output entry_t          q_entry_o
);

  tok_e tok;

  always_comb begin
    if (!s_axis_tuser) begin
      tok = TOK_NONE;
    end else begin
      case (s_axis_tdata)
        ChrQuote: tok = TOK_QUOTE;
        ChrComma: tok = TOK_COMMA;
        ChrLf:    tok = TOK_LF;
        ChrCr:    tok = TOK_CR;
        default:  tok = TOK_OTHER;
      endcase
    end
  end

  assign s_axis_tready = !q_full_i;
  // A beat with neither a byte nor an end mark changes nothing, so it is dropped here.
  assign q_push_o  = s_axis_tvalid && !q_full_i && (s_axis_tuser || s_axis_tlast);
  assign q_entry_o = '{tok: tok, last: s_axis_tlast};

endmodule
`default_nettype wire

// ===== sv/csc_queue.sv =====
// Short token queue between the front end and the back end.
`default_nettype none
module csc_queue
  import csc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  entry_t      entry_i,
  output logic        full_o,
  output logic        valid_o,
  output entry_t      entry_o,
  input  wire logic   pop_i
);

  localparam int unsigned PtrWidth = $clog2(QueueDepth);
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  entry_t                mem_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic                  do_pop;

  assign full_o  = (count_q == CntWidth'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/csc_back.sv =====
// Back end: runs the quoting and record tracker on tokens and holds the result.
`default_nettype none
module csc_back
  import csc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_valid_i,
  input  entry_t      q_entry_i,
  output logic        q_pop_o,
  output logic        res_valid_o,
  input  wire logic   res_ready_i,
  output result_t     res_o
);

  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);

  typedef struct packed {
    logic                   quoted;
    logic                   quote_pend;
    logic                   cr_pend;
    logic                   has_content;
    logic [COUNT_WIDTH-1:0] cur_cols;
    logic [COUNT_WIDTH-1:0] first_cols;
    logic [COUNT_WIDTH-1:0] records;
    fault_e                 fault;
    logic                   any_byte;
    logic                   sat;
  } track_t;

  localparam track_t TrackReset = '{
    quoted: 1'b0, quote_pend: 1'b0, cr_pend: 1'b0, has_content: 1'b0,
    cur_cols: CntOne, first_cols: '0, records: '0, fault: FAULT_NONE,
    any_byte: 1'b0, sat: 1'b0};

  function automatic logic [COUNT_WIDTH-1:0] sat_next(input logic [COUNT_WIDTH-1:0] v);
    sat_next = (v == CntMax) ? CntMax : v + 1'b1;
  endfunction

  function automatic track_t close_record(input track_t s);
    track_t r;
    r = s;
    if (!s.has_content && s.cur_cols == CntOne) begin
      r.fault = FAULT_BLANK;
    end else if (s.records != '0 && s.first_cols != s.cur_cols) begin
      r.fault = FAULT_MISMATCH;
    end else begin
      if (s.records == '0) begin
        r.first_cols = s.cur_cols;
      end
      r.records     = sat_next(s.records);
      r.sat         = s.sat || (s.records >= CntMax - 1'b1);
      r.cur_cols    = CntOne;
      r.has_content = 1'b0;
    end
    return r;
  endfunction

  track_t  st_q, st_d, st_b, st_e;
  logic    res_valid_q;
  result_t res_q;
  logic    can_take;
  logic    skip;
  logic    ok;

  // A beat that ends the text needs the result register free; others never wait.
  assign can_take = !q_entry_i.last || !res_valid_q || res_ready_i;
  assign q_pop_o  = q_valid_i && can_take;

  // Effect of the byte itself.
  always_comb begin
    st_b = st_q;
    skip = 1'b0;
    if (q_entry_i.tok != TOK_NONE) begin
      st_b.any_byte = 1'b1;
      if (st_q.fault == FAULT_NONE) begin
        if (st_b.quote_pend) begin
          st_b.quote_pend = 1'b0;
          if (q_entry_i.tok == TOK_QUOTE) begin
            skip = 1'b1;
          end else begin
            st_b.quoted = 1'b0;
          end
        end
        if (!skip && st_b.cr_pend) begin
          st_b.cr_pend = 1'b0;
          if (q_entry_i.tok == TOK_LF) begin
            skip = 1'b1;
          end
        end
        if (!skip) begin
          if (q_entry_i.tok == TOK_QUOTE) begin
            st_b.has_content = 1'b1;
            if (st_b.quoted) begin
              st_b.quote_pend = 1'b1;
            end else begin
              st_b.quoted = 1'b1;
            end
          end else if (!st_b.quoted && q_entry_i.tok == TOK_COMMA) begin
            st_b.sat         = st_b.sat || (st_b.cur_cols >= CntMax - 1'b1);
            st_b.cur_cols    = sat_next(st_b.cur_cols);
            st_b.has_content = 1'b1;
          end else if (!st_b.quoted &&
                       (q_entry_i.tok == TOK_LF || q_entry_i.tok == TOK_CR)) begin
            st_b = close_record(st_b);
            if (st_b.fault == FAULT_NONE && q_entry_i.tok == TOK_CR) begin
              st_b.cr_pend = 1'b1;
            end
          end else begin
            st_b.has_content = 1'b1;
          end
        end
      end
    end
  end

  // Effect of the end mark, applied after the byte.
  always_comb begin
    st_e = st_b;
    if (st_b.fault == FAULT_NONE) begin
      if (st_e.quote_pend) begin
        st_e.quote_pend = 1'b0;
        st_e.quoted     = 1'b0;
      end
      st_e.cr_pend = 1'b0;
      if (!st_e.any_byte) begin
        st_e.fault = FAULT_EMPTY;
      end else if (st_e.quoted) begin
        st_e.fault = FAULT_OPEN_QUOTE;
      end else if (st_e.has_content || st_e.cur_cols > CntOne) begin
        st_e = close_record(st_e);
      end
    end
    ok = (st_e.fault == FAULT_NONE) && (st_e.records != '0);
  end

  always_comb begin
    st_d = st_q;
    if (q_pop_o) begin
      st_d = q_entry_i.last ? TrackReset : st_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= TrackReset;
      res_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (q_pop_o && q_entry_i.last) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_entry_i.last) begin
      res_q.valid   <= ok;
      res_q.columns <= ok ? OutFieldWidth'(st_e.first_cols) : '0;
      res_q.records <= ok ? OutFieldWidth'(st_e.records) : '0;
      res_q.fault   <= st_e.fault;
      res_q.sat     <= st_e.sat;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== sv/csv_shape_checker.sv =====
// Top level of the CSV shape checker.
// Takes CSV text one byte per beat and gives one result beat after the beat
// marked tlast. A front end classifies each byte and pushes a token into a
// two-entry queue; the back end retires one token per cycle, so a byte can be
// accepted in every cycle while the output register is free. The tracker
// step sets that rate. The result sits in that register; while it waits to
// be taken, bytes of the next text keep flowing until the queue fills behind
// an end-of-text token. Counts are COUNT_WIDTH bits wide and saturate.
`default_nettype none
module csv_shape_checker
  import csc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: data_byte[7:0]
  input  wire logic [7:0]              s_axis_tdata,
  // tuser: byte_present[0]
  input  wire logic                    s_axis_tuser,
  // tlast: last_byte
  input  wire logic                    s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // tdata: shape_valid[0], column_count[16:1], record_count[32:17],
  // fault_code[35:33], count_saturated[36], zero fill[39:37]
  output logic [OutDataWidth-1:0]      m_axis_tdata
);

  logic    q_full, q_push, q_valid, q_pop;
  entry_t  q_in, q_out;
  result_t res;

  csc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  csc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_out),
    .pop_i   (q_pop)
  );

  csc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.sat, res.fault, res.records, res.columns, res.valid};

endmodule
`default_nettype wire

// ===== sv/csc_checker.sv =====
// Port-level checks of the CSV shape checker and their binding to the top level.
`default_nettype none
module csc_checker
  import csc_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    s_axis_tready,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [OutDataWidth-1:0] m_axis_tdata
);

  logic   ok_bit;
  logic   sat_bit;
  fault_e fault;
  logic [OutFieldWidth-1:0] cols, recs;

  assign ok_bit  = m_axis_tdata[0];
  assign cols    = m_axis_tdata[16:1];
  assign recs    = m_axis_tdata[32:17];
  assign fault   = fault_e'(m_axis_tdata[35:33]);
  assign sat_bit = m_axis_tdata[36];

  // A stalled result beat holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // A valid verdict carries no fault and at least one record and one column.
  a_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ok_bit |-> fault == FAULT_NONE && recs != '0 && cols != '0)
    else $error("valid verdict with fault or zero count");

  // An invalid verdict reports zero counts.
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !ok_bit |-> recs == '0 && cols == '0 && m_axis_tdata[39:37] == '0)
    else $error("invalid verdict with nonzero counts");

  // Saturation cannot show without a valid count or a fault on tiny texts:
  // a saturated empty text is impossible.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && fault == FAULT_EMPTY |-> !sat_bit)
    else $error("empty text reported as saturated");

  // After reset the input side is open for a beat.
  a_rdy: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready)
    else $error("input not ready after reset");

endmodule

bind csv_shape_checker csc_checker u_csc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== dv/csv_shape_checker_tb.sv =====
// Self-checking testbench for the CSV shape checker: directed table and random texts.
`timescale 1ns / 1ps

module csv_shape_checker_tb;
  import csc_pkg::*;

  localparam int unsigned CountMax    = (1 << CountWidthDefault) - 1;
  localparam int          ResultWidth = $bits(result_t);
  localparam int          FillWidth   = OutDataWidth - ResultWidth;
  localparam int          RandomBeats = 1300;
  localparam int          DrainCycles = 20;
  localparam int          TextMax     = 2048;
  localparam int          ReportMax   = 4096;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata;
  logic                    s_axis_tuser;
  logic                    s_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;

  csv_shape_checker dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Shape tracker state, mirrored from the block.
  logic        quoted;
  logic        quote_wait;
  logic        cr_wait;
  logic        has_content;
  logic        seen_byte;
  logic        hit_max;
  int unsigned cur_cols;
  int unsigned first_cols;
  int unsigned rec_total;
  fault_e      first_fault;

  result_t     awaited_reports[ReportMax];
  int          rpt_wr;
  int          rpt_rd;
  logic [7:0]  text_bytes[TextMax];
  int          text_len;
  int          beats_sent;
  int          report_errors;
  bit          idle_on;
  result_t     seen_report;
  result_t     want_report;
  logic [FillWidth-1:0] seen_fill;

  function automatic void clear_tracker();
    quoted      = 1'b0;
    quote_wait  = 1'b0;
    cr_wait     = 1'b0;
    has_content = 1'b0;
    seen_byte   = 1'b0;
    hit_max     = 1'b0;
    cur_cols    = 1;
    first_cols  = 0;
    rec_total   = 0;
    first_fault = FAULT_NONE;
  endfunction

  function automatic void append_byte(input logic [7:0] c);
    text_bytes[text_len] = c;
    text_len++;
  endfunction

  function automatic int unsigned count_up(int unsigned v);
    if (v >= CountMax) begin
      hit_max = 1'b1;
      return CountMax;
    end
    if (v + 1 == CountMax) hit_max = 1'b1;
    return v + 1;
  endfunction

  function automatic void end_record();
    if (!has_content && cur_cols == 1) begin
      first_fault = FAULT_BLANK;
      return;
    end
    if (rec_total == 0) begin
      first_cols = cur_cols;
    end else if (first_cols != cur_cols) begin
      first_fault = FAULT_MISMATCH;
      return;
    end
    rec_total   = count_up(rec_total);
    cur_cols    = 1;
    has_content = 1'b0;
  endfunction

  function automatic void track_char(logic [7:0] c);
    if (quote_wait) begin
      quote_wait = 1'b0;
      // Two quotes in a row inside a quoted field are one literal quote.
      if (c == ChrQuote) return;
      quoted = 1'b0;
    end
    if (cr_wait) begin
      cr_wait = 1'b0;
      if (c == ChrLf) return;
    end
    if (c == ChrQuote) begin
      has_content = 1'b1;
      if (quoted) quote_wait = 1'b1;
      else quoted = 1'b1;
      return;
    end
    if (!quoted && c == ChrComma) begin
      cur_cols    = count_up(cur_cols);
      has_content = 1'b1;
      return;
    end
    if (!quoted && (c == ChrLf || c == ChrCr)) begin
      end_record();
      if (first_fault == FAULT_NONE && c == ChrCr) cr_wait = 1'b1;
      return;
    end
    has_content = 1'b1;
  endfunction

  function automatic void shape_step(input logic [7:0] c, input logic present,
                                     input logic is_last, output bit ended,
                                     output result_t rpt);
    logic ok;
    ended = 1'b0;
    rpt   = '0;
    if (present) begin
      seen_byte = 1'b1;
      if (first_fault == FAULT_NONE) track_char(c);
    end
    if (!is_last) return;
    if (first_fault == FAULT_NONE) begin
      // A quote still waiting for its partner closes the field.
      if (quote_wait) begin
        quote_wait = 1'b0;
        quoted     = 1'b0;
      end
      cr_wait = 1'b0;
      if (!seen_byte) first_fault = FAULT_EMPTY;
      else if (quoted) first_fault = FAULT_OPEN_QUOTE;
      else if (has_content || cur_cols > 1) end_record();
    end
    ok          = first_fault == FAULT_NONE && rec_total > 0;
    rpt.valid   = ok;
    rpt.columns = ok ? OutFieldWidth'(first_cols) : '0;
    rpt.records = ok ? OutFieldWidth'(rec_total) : '0;
    rpt.fault   = first_fault;
    rpt.sat     = hit_max;
    ended       = 1'b1;
    clear_tracker();
  endfunction

  // Drives one beat, waits for it to be taken and records what it should produce.
  // A fault other than FAULT_NONE in typed_fault replaces the predicted report.
  task automatic send_beat(input logic [7:0] c, input logic present, input logic is_last,
                           input fault_e typed_fault);
    bit      ended;
    result_t rpt;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= present;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    shape_step(c, present, is_last, ended, rpt);
    if (ended) begin
      if (typed_fault != FAULT_NONE) begin
        rpt       = '0;
        rpt.fault = typed_fault;
      end
      awaited_reports[rpt_wr % ReportMax] = rpt;
      rpt_wr++;
    end
    beats_sent++;
  endtask

  // Sends text_bytes as one text, either marking the final byte or with an empty end beat.
  task automatic send_text();
    bit end_on_byte;
    end_on_byte = text_len > 0 && $urandom_range(0, 1) != 0;
    for (int i = 0; i < text_len; i++) begin
      if ($urandom_range(0, 15) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0,
                                                 FAULT_NONE);
      send_beat(text_bytes[i], 1'b1, end_on_byte && i == text_len - 1, FAULT_NONE);
    end
    if (!end_on_byte) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, FAULT_NONE);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ChrQuote || c == ChrComma || c == ChrCr || c == ChrLf);
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 5))
      0: return ChrQuote;
      1: return ChrComma;
      2: return ChrCr;
      3: return ChrLf;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_field(input bit allow_empty);
    if ($urandom_range(0, 3) == 0) begin
      append_byte(ChrQuote);
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 5))
          0: begin
            append_byte(ChrQuote);
            append_byte(ChrQuote);
          end
          1: append_byte(ChrComma);
          2: append_byte(ChrCr);
          3: append_byte(ChrLf);
          default: append_byte(plain_char());
        endcase
      end
      append_byte(ChrQuote);
    end else begin
      repeat ($urandom_range(allow_empty ? 0 : 1, 4)) append_byte(plain_char());
    end
  endtask

  task automatic add_record(input int ncols);
    for (int col = 0; col < ncols; col++) begin
      if (col > 0) append_byte(ChrComma);
      add_field(ncols > 1);
    end
  endtask

  task automatic add_newline();
    case ($urandom_range(0, 2))
      0: append_byte(ChrLf);
      1: append_byte(ChrCr);
      default: begin
        append_byte(ChrCr);
        append_byte(ChrLf);
      end
    endcase
  endtask

  // Mostly well-formed texts; some get an odd record, a blank line, an open quote or noise.
  task automatic build_text();
    int kind;
    int ncols;
    int nrec;
    int odd_rec;
    int odd_cols;
    text_len = 0;
    kind = $urandom_range(0, 19);
    if (kind >= 17) begin
      repeat ($urandom_range(0, 12)) append_byte(noise_char());
      return;
    end
    ncols    = $urandom_range(1, 5);
    nrec     = $urandom_range(1, 6);
    odd_rec  = (kind == 14) ? $urandom_range(0, nrec - 1) : -1;
    odd_cols = (ncols > 1 && $urandom_range(0, 1)) ? ncols - 1 : ncols + 1;
    for (int r = 0; r < nrec; r++) begin
      add_record(r == odd_rec ? odd_cols : ncols);
      if (r < nrec - 1 || $urandom_range(0, 1)) add_newline();
    end
    if (kind == 15) begin
      // The second LF always lands on an empty record, whatever ended the last one.
      append_byte(ChrLf);
      append_byte(ChrLf);
    end
    if (kind == 16) begin
      append_byte(ChrQuote);
      append_byte(plain_char());
    end
  endtask

  typedef struct packed {
    logic [7:0] chr;
    logic       present;
    logic       is_last;
    fault_e     typed_fault;
  } stim_row_t;

  localparam int DirectedRows = 25;

  stim_row_t directed_rows [DirectedRows] = '{
    // Text without any byte.
    '{8'h00,    1'b0, 1'b1, FAULT_EMPTY},
    // CR LF pair, a no-op beat, then a CR still pending at the end.
    '{ChrComma, 1'b1, 1'b0, FAULT_NONE},
    '{ChrCr,    1'b1, 1'b0, FAULT_NONE},
    '{ChrLf,    1'b1, 1'b0, FAULT_NONE},
    '{8'h5A,    1'b0, 1'b0, FAULT_NONE},
    '{ChrComma, 1'b1, 1'b0, FAULT_NONE},
    '{ChrCr,    1'b1, 1'b1, FAULT_NONE},
    // Doubled quote inside a quoted field; the closing quote is resolved by a comma.
    '{ChrQuote, 1'b1, 1'b0, FAULT_NONE},
    '{ChrQuote, 1'b1, 1'b0, FAULT_NONE},
    '{ChrQuote, 1'b1, 1'b0, FAULT_NONE},
    '{ChrQuote, 1'b1, 1'b0, FAULT_NONE},
    '{ChrComma, 1'b1, 1'b1, FAULT_NONE},
    // Quote still pending when the text ends.
    '{ChrQuote, 1'b1, 1'b0, FAULT_NONE},
    '{8'h71,    1'b1, 1'b0, FAULT_NONE},
    '{ChrQuote, 1'b1, 1'b1, FAULT_NONE},
    // Column mismatch, with the extreme byte values as content.
    '{8'hFF,    1'b1, 1'b0, FAULT_NONE},
    '{ChrLf,    1'b1, 1'b0, FAULT_NONE},
    '{8'h00,    1'b1, 1'b0, FAULT_NONE},
    '{ChrComma, 1'b1, 1'b0, FAULT_NONE},
    '{8'hFF,    1'b1, 1'b1, FAULT_MISMATCH},
    // Blank record; the open quote after it must be ignored.
    '{8'h00,    1'b1, 1'b0, FAULT_NONE},
    '{ChrLf,    1'b1, 1'b0, FAULT_NONE},
    '{ChrLf,    1'b1, 1'b0, FAULT_NONE},
    '{ChrQuote, 1'b1, 1'b1, FAULT_BLANK},
    // Quote left open.
    '{ChrQuote, 1'b1, 1'b1, FAULT_OPEN_QUOTE}
  };

  task automatic log_mismatch(input string what, input result_t want, input result_t got,
                              input logic [FillWidth-1:0] fill);
    report_errors++;
    if (report_errors <= 10) begin
      $display("%s: expected valid=%0d cols=%0d recs=%0d fault=%0d sat=%0d fill=0",
               what, want.valid, want.columns, want.records, want.fault, want.sat);
      $display("  got valid=%0d cols=%0d recs=%0d fault=%0d sat=%0d fill=%0d",
               got.valid, got.columns, got.records, got.fault, got.sat, fill);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_report = result_t'(m_axis_tdata[ResultWidth-1:0]);
      seen_fill   = m_axis_tdata[OutDataWidth-1:ResultWidth];
      if (rpt_wr == rpt_rd) begin
        log_mismatch("report with none awaited", '0, seen_report, seen_fill);
      end else begin
        want_report = awaited_reports[rpt_rd % ReportMax];
        rpt_rd++;
        if (seen_report.valid != want_report.valid ||
            seen_report.columns != want_report.columns ||
            seen_report.records != want_report.records ||
            seen_report.fault != want_report.fault ||
            seen_report.sat != want_report.sat ||
            seen_fill != '0) begin
          log_mismatch("report mismatch", want_report, seen_report, seen_fill);
        end
      end
    end
  end

  // Result side: ready drops in short random bursts while idling is on.
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int random_start;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    beats_sent    = 0;
    report_errors = 0;
    rpt_wr        = 0;
    rpt_rd        = 0;
    text_len      = 0;
    idle_on       = 1'b1;
    clear_tracker();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].chr, directed_rows[i].present, directed_rows[i].is_last,
                directed_rows[i].typed_fault);
    end

    random_start = beats_sent;
    while (beats_sent - random_start < RandomBeats) begin
      if (beats_sent - random_start > RandomBeats * 3 / 4) idle_on = 1'b0;
      build_text();
      send_text();
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (rpt_wr != rpt_rd) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (report_errors == 0 && rpt_wr == rpt_rd) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/csc_pkg.sv
sv/csc_front.sv
sv/csc_queue.sv
sv/csc_back.sv
sv/csv_shape_checker.sv
sv/csc_checker.sv
dv/csv_shape_checker_tb.sv
